@@ src/lcas_pkg.sv @@
package lcas_pkg;

  localparam int CfgW  = 9;
  localparam int RowW  = 10;
  localparam int IdxW  = 8;

  localparam logic [0:0] OpCell = 1'b0;
  localparam logic [0:0] OpPad  = 1'b1;

  localparam logic [0:0] RegRowsUsed = 1'b0;
  localparam logic [0:0] RegColsUsed = 1'b1;

  localparam logic [CfgW-1:0] RowsUsedReset = 9'd200;
  localparam logic [CfgW-1:0] ColsUsedReset = 9'd200;

  typedef struct packed {
    logic [0:0] opcode;
    logic       cell_alive;
  } in_t;

  typedef struct packed {
    logic            next_alive;
    logic [IdxW-1:0] out_row;
    logic [IdxW-1:0] out_col;
    logic            last_of_frame;
  } out_t;

  // window bit = col*3 + row; col 0 is left, row 0 is top, center is bit 4
  function automatic logic life_next(logic [8:0] win, logic top_dead, logic bot_dead);
    logic [8:0] w;
    logic [3:0] n;
    w = win;
    n = '0;
    if (top_dead) begin
      w = w & ~9'h049;
    end
    if (bot_dead) begin
      w = w & ~9'h124;
    end
    for (int i = 0; i < 9; i++) begin
      if (i != 4) begin
        n = n + 4'(w[i]);
      end
    end
    if (w[4]) begin
      life_next = (n == 4'd2) || (n == 4'd3);
    end else begin
      life_next = (n == 4'd3);
    end
  endfunction

endpackage

@@ src/lcas_ram.sv @@
module lcas_ram #(
  parameter int Width = 2,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/life_cellular_automaton_stencil.sv @@
// B3/S23 life stencil: one generation over a grid streamed in raster order.
// Input channel (in_valid_i / in_stall_o / in_data_i): one cell per
// transaction, row by row, opcode = cell. After each frame send cols_used+1
// padding transactions (opcode = pad) to flush the last results.
// Output channel (out_valid_o / out_stall_i / out_data_o): the next state of
// a cell with its row and column; the final cell of the grid carries
// last_of_frame. The result for a cell leaves with the input transaction
// cols_used+1 places later in raster order.
// Throughput is one transaction per cycle while out_stall_i is low. An
// accepted item sits in the input stage while the line-store RAM read
// completes, and its result is loaded into the output register when that
// stage advances. Both line stores sit in one 2-bit wide RAM with
// registered read.
// With out_valid_o set, a high out_stall_i holds the output register, the
// input stage fills and in_stall_o rises. Reset empties the pipeline, clears
// the position counters and the window and sets rows_used and cols_used to
// 200. Line-store contents after reset only feed rows above the top edge.
// Registers: rows_used at byte address 0, cols_used at 4 (APB, 9 bits each).
module life_cellular_automaton_stencil #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lcas_pkg::in_t       in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lcas_pkg::out_t      out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int AW = $clog2(MAX_COLS);
  localparam int CW = lcas_pkg::CfgW;
  localparam int RW = lcas_pkg::RowW;
  localparam int IW = lcas_pkg::IdxW;

  logic [CW-1:0] rows_used_q, cols_used_q;
  logic [CW-1:0] rows, cols;
  logic          cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_used_q <= lcas_pkg::RowsUsedReset;
      cols_used_q <= lcas_pkg::ColsUsedReset;
    end else if (cfg_we) begin
      if (paddr[2] == lcas_pkg::RegRowsUsed) begin
        rows_used_q <= pwdata[CW-1:0];
      end else begin
        cols_used_q <= pwdata[CW-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == lcas_pkg::RegRowsUsed) begin
      prdata = 32'(rows_used_q);
    end else begin
      prdata = 32'(cols_used_q);
    end
  end

  assign rows = (rows_used_q == '0) ? CW'(1) :
                (32'(rows_used_q) > MAX_ROWS) ? CW'(MAX_ROWS) : rows_used_q;
  assign cols = (cols_used_q == '0) ? CW'(1) :
                (32'(cols_used_q) > MAX_COLS) ? CW'(MAX_COLS) : cols_used_q;

  // input position
  logic [AW-1:0] ic_q, ic_d, acc_ic;
  logic [RW-1:0] ir_q, ir_d, acc_ir;
  logic [AW:0]   ic_inc;

  // input stage
  logic          s1_valid_q;
  logic          s1_v_q;
  logic [AW-1:0] s1_ic_q;
  logic [RW-1:0] s1_ir_q;
  logic          s1_adv, accept;

  // output register
  logic           out_valid_q;
  lcas_pkg::out_t out_q;

  logic [8:0] win_q, win_d;
  logic [1:0] ram_rdata, ram_wdata, fwd_q, lines;
  logic       fwd_hit_q;

  logic [RW:0] rows_x;
  logic [RW:0] ir_x;
  logic        emit;
  lcas_pkg::out_t res;
  logic [8:0]  shifted, col_bits;

  assign s1_adv     = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~s1_adv;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    acc_ic = ic_q;
    acc_ir = ir_q;
    if (32'(ic_q) >= 32'(cols)) begin
      acc_ic = '0;
      acc_ir = ir_q + RW'(1);
    end
    ic_inc = {1'b0, acc_ic} + (AW+1)'(1);
    if ((acc_ic == '0) && (32'(acc_ir) >= 32'(rows) + 32'd1)) begin
      ic_d = '0;
      ir_d = '0;
    end else if (32'(ic_inc) >= 32'(cols)) begin
      ic_d = '0;
      ir_d = acc_ir + RW'(1);
    end else begin
      ic_d = ic_inc[AW-1:0];
      ir_d = acc_ir;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ic_q       <= '0;
      ir_q       <= '0;
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      if (accept) begin
        ic_q      <= ic_d;
        ir_q      <= ir_d;
        fwd_hit_q <= s1_adv & (s1_ic_q == acc_ic);
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_v_q  <= (in_data_i.opcode == lcas_pkg::OpPad) ? 1'b0 : in_data_i.cell_alive;
      s1_ic_q <= acc_ic;
      s1_ir_q <= acc_ir;
    end
    if (accept & s1_adv) begin
      fwd_q <= ram_wdata;
    end
  end

  // bit 0: upper line, bit 1: middle line
  assign lines     = fwd_hit_q ? fwd_q : ram_rdata;
  assign ram_wdata = {s1_v_q, lines[1]};

  lcas_ram #(
    .Width (2),
    .Depth (MAX_COLS)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_ic_q),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (acc_ic),
    .rdata_o (ram_rdata)
  );

  assign rows_x   = {1'b0, RW'(rows)};
  assign ir_x     = {1'b0, s1_ir_q};
  assign shifted  = {3'b000, win_q[8:3]};
  assign col_bits = {s1_v_q, lines[1], lines[0], 6'b000000};

  always_comb begin
    emit = 1'b0;
    res  = '0;
    if (s1_ic_q == '0) begin
      if ((ir_x >= (RW+1)'(2)) && (ir_x < rows_x + (RW+1)'(2))) begin
        emit              = 1'b1;
        res.next_alive    = lcas_pkg::life_next(shifted, ir_x == (RW+1)'(2),
                                                ir_x >= rows_x + (RW+1)'(1));
        res.out_row       = IW'(s1_ir_q - RW'(2));
        res.out_col       = IW'(cols - CW'(1));
        res.last_of_frame = (ir_x == rows_x + (RW+1)'(1));
      end
      if (ir_x >= rows_x + (RW+1)'(1)) begin
        win_d = '0;
      end else begin
        win_d = col_bits;
      end
    end else begin
      win_d = shifted | col_bits;
      if ((ir_x >= (RW+1)'(1)) && (ir_x < rows_x + (RW+1)'(1))) begin
        emit              = 1'b1;
        res.next_alive    = lcas_pkg::life_next(win_d, ir_x == (RW+1)'(1),
                                                ir_x >= rows_x);
        res.out_row       = IW'(s1_ir_q - RW'(1));
        res.out_col       = IW'(s1_ic_q - AW'(1));
        res.last_of_frame = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        win_q <= win_d;
      end
      if (s1_adv & emit) begin
        out_valid_q <= 1'b1;
      end else begin
        out_valid_q <= out_valid_q & out_stall_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv & emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
